@@ sv/lpf_pkg.sv @@
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types and constants for the LED PWM fade/pulse controller.
// ----------------------------------------------------------------------------
package lpf_pkg;

    // Item commands carried in s_tuser.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_DIM   = 2'd2,
        CMD_PULSE = 2'd3
    } cmd_t;

    // Per-channel fade mode.
    typedef enum logic [2:0] {
        MODE_STOP       = 3'd0,
        MODE_DIM_UP     = 3'd1,
        MODE_DIM_DOWN   = 3'd2,
        MODE_PULSE_UP   = 3'd3,
        MODE_PULSE_DOWN = 3'd4
    } mode_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_PULSE_FLOOR   = 2'd0;
    localparam logic [1:0] REG_PULSE_CEILING = 2'd1;
    localparam logic [1:0] REG_STEP_PERIOD   = 2'd2;

    // Brightness limits and register reset values.
    localparam logic [6:0] LEVEL_MAX           = 7'd100;
    localparam logic [6:0] PHASE_TOP           = 7'd100;
    localparam logic [6:0] PULSE_FLOOR_RESET   = 7'd5;
    localparam logic [6:0] PULSE_CEILING_RESET = 7'd100;
    localparam logic [7:0] STEP_PERIOD_RESET   = 8'd150;

    // Width of the lit mask reported in the result.
    localparam int LIT_BITS = 5;

    // One channel's entry in the state memory.
    typedef struct packed {
        mode_t      mode;
        logic [6:0] goal;
        logic [6:0] level;
    } entry_t;

endpackage

@@ sv/lpf_ram.sv @@
// ----------------------------------------------------------------------------
// lpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/led_pwm_fade_pulse_controller.sv @@
// ----------------------------------------------------------------------------
// led_pwm_fade_pulse_controller
// Multichannel LED PWM controller with per-channel fade and pulse modes.
// ----------------------------------------------------------------------------
// Sequence: a tick goes through FETCH, then UPDATE for every channel in turn,
// then DONE; a command on a valid channel goes through FETCH, UPDATE and DONE,
// and a command on an absent channel goes straight to DONE. A new item is taken
// only in IDLE, once the last result has been handed off; the state memory is
// walked one entry per cycle. A stalled sink holds the next result in DONE.
// Reset (aresetn low, synchronous) clears all channels through valid bits.
module led_pwm_fade_pulse_controller
    import lpf_pkg::*;
#(
    parameter int NUM_CHANNELS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] channel, [10:3] level, [11] pulse_enable
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [4:0] led_lit
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LW    = (NUM_CHANNELS > LIT_BITS) ? NUM_CHANNELS : LIT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    // Configuration registers.
    logic [6:0] pulse_floor_reg;
    logic [6:0] pulse_ceiling_reg;
    logic [7:0] step_period_reg;

    // Global PWM state.
    logic [6:0] pwm_phase_reg;
    logic [8:0] step_timer_reg;
    logic [NUM_CHANNELS-1:0] lit_reg;
    logic [NUM_CHANNELS-1:0] vld_reg;

    // Latched item.
    cmd_t             cmd_reg;
    logic [6:0]       lv_reg;
    logic             en_reg;
    logic             fire_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    // Sequencer.
    state_t state_reg;
    state_t state_next;

    // Memory port signals.
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_we;
    entry_t           ram_rdata;
    entry_t           ram_wdata;

    // Result register.
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    logic       s_accept;
    logic       out_free;
    logic       ch_ok;
    logic [6:0] s_level_clamped;
    entry_t     cur;
    logic       lit_new;
    logic [LW-1:0] lit_ext;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ch_ok    = 32'(s_tdata[2:0]) < NUM_CHANNELS;
    assign s_level_clamped = (s_tdata[10:3] > 8'(LEVEL_MAX)) ? LEVEL_MAX : s_tdata[9:3];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Channel state memory: one entry per channel.
    lpf_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (cmd_t'(s_tuser) != CMD_TICK && !ch_ok) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (cmd_reg != CMD_TICK || idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        ram_we    = 1'b0;
        idx_next  = idx_reg;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_FETCH: ram_re = 1'b1;
            ST_UPDATE: begin
                ram_we = 1'b1;
                // A tick reads the next channel while writing this one.
                if (cmd_reg == CMD_TICK && idx_reg != LAST_IDX) begin
                    idx_next  = idx_reg + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = idx_next;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // Entry as read, with never-written entries standing at their reset value.
    always_comb begin
        if (vld_reg[idx_reg]) begin
            cur = ram_rdata;
        end else begin
            cur.mode  = MODE_STOP;
            cur.goal  = '0;
            cur.level = '0;
        end
    end

    // Read-modify-write of one channel entry.
    always_comb begin
        ram_wdata = cur;
        lit_new   = lit_reg[idx_reg];
        case (cmd_reg)
            CMD_TICK: begin
                // PWM: off once the phase passes the level, on again at wrap.
                if (pwm_phase_reg > cur.level) begin
                    lit_new = 1'b0;
                end
                if (pwm_phase_reg == PHASE_TOP && cur.level != '0) begin
                    lit_new = 1'b1;
                end
                if (fire_reg) begin
                    case (cur.mode)
                        MODE_DIM_UP, MODE_DIM_DOWN: begin
                            if (cur.level == cur.goal) begin
                                ram_wdata.mode = MODE_STOP;
                            end else if (cur.mode == MODE_DIM_DOWN) begin
                                ram_wdata.level = cur.level - 1'b1;
                            end else begin
                                ram_wdata.level = cur.level + 1'b1;
                            end
                        end
                        MODE_PULSE_UP: begin
                            if (cur.level >= pulse_ceiling_reg) begin
                                ram_wdata.mode = MODE_PULSE_DOWN;
                            end else begin
                                ram_wdata.level = cur.level + 1'b1;
                            end
                        end
                        MODE_PULSE_DOWN: begin
                            if (cur.level <= pulse_floor_reg) begin
                                ram_wdata.mode = MODE_PULSE_UP;
                            end else begin
                                ram_wdata.level = cur.level - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_SET: begin
                ram_wdata.level = lv_reg;
                ram_wdata.goal  = lv_reg;
                ram_wdata.mode  = MODE_STOP;
            end
            CMD_DIM: begin
                if (lv_reg > cur.level) begin
                    ram_wdata.mode = MODE_DIM_UP;
                    ram_wdata.goal = lv_reg;
                end else if (lv_reg < cur.level) begin
                    ram_wdata.mode = MODE_DIM_DOWN;
                    ram_wdata.goal = lv_reg;
                end
            end
            CMD_PULSE: begin
                ram_wdata.mode = en_reg ? MODE_PULSE_UP : MODE_STOP;
            end
            default: ;
        endcase
    end

    assign lit_ext = LW'(lit_reg);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            pulse_floor_reg   <= PULSE_FLOOR_RESET;
            pulse_ceiling_reg <= PULSE_CEILING_RESET;
            step_period_reg   <= STEP_PERIOD_RESET;
            pwm_phase_reg     <= '0;
            step_timer_reg    <= '0;
            lit_reg           <= '0;
            vld_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Register writes.
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PULSE_FLOOR:   pulse_floor_reg   <= cfg_wdata[6:0];
                    REG_PULSE_CEILING: pulse_ceiling_reg <= cfg_wdata[6:0];
                    REG_STEP_PERIOD:   step_period_reg   <= cfg_wdata;
                    default: ;
                endcase
            end

            // Entry write-back and lit update.
            if (state_reg == ST_UPDATE) begin
                vld_reg[idx_reg] <= 1'b1;
                if (cmd_reg == CMD_TICK) begin
                    lit_reg[idx_reg] <= lit_new;
                end
            end

            // Result handoff.
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // A tick advances phase and step timer as its result is handed off.
            if (state_reg == ST_DONE && out_free && cmd_reg == CMD_TICK) begin
                pwm_phase_reg <= (pwm_phase_reg == PHASE_TOP) ? '0
                                                              : pwm_phase_reg + 1'b1;
                step_timer_reg <= fire_reg ? '0 : step_timer_reg + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= cmd_t'(s_tuser);
            lv_reg   <= s_level_clamped;
            en_reg   <= s_tdata[11];
            fire_reg <= step_timer_reg > {1'b0, step_period_reg};
            idx_reg  <= (cmd_t'(s_tuser) == CMD_TICK) ? '0 : IDX_W'(s_tdata[2:0]);
        end else if (state_reg == ST_UPDATE) begin
            idx_reg <= idx_next;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {3'b000, lit_ext[LIT_BITS-1:0]};
        end
    end

endmodule

@@ sv/lpf_checker.sv @@
// ----------------------------------------------------------------------------
// lpf_checker
// Port-level checks for the LED PWM fade/pulse controller.
// ----------------------------------------------------------------------------
module lpf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only five lit bits are ever reported.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:5] == 3'b000)
        else $error("padding bits of result set");

    // One item is in work at a time: input closes after each beat.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

bind led_pwm_fade_pulse_controller lpf_checker u_lpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
